// File: hdl/fir_ec_pkg.sv
// fir_ec_pkg: shared widths, defaults and register map for the edge-clamped FIR.
// No dependencies; compiled first.
package fir_ec_pkg;

	localparam int SAMPLE_W  = 16;                    // input sample width
	localparam int COEFF_W   = 16;                    // Q1.15 coefficient width
	localparam int PROD_W    = SAMPLE_W + COEFF_W;    // one tap product
	localparam int OUT_W     = 35;                    // filtered result width
	localparam int TAPS_DEF  = 8;                     // default tap count
	localparam int NUM_REGS  = 8;                     // coefficient registers on the bus
	localparam int GRP       = 4;                     // products per first-level adder
	localparam int PDATA_W   = 32;                    // APB data width
	localparam int PADDR_W   = 5;                     // 8 word registers
	localparam int REG_IDX_W = 3;                     // register index bits in paddr

	localparam logic signed [COEFF_W-1:0] COEFF0_RST = 16'sd32767;

endpackage

// File: hdl/fir_ec_in_if.sv
// fir_ec_in_if: sample request channel (valid/ready plus sample, block_start).
// Depends on fir_ec_pkg.
interface fir_ec_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fir_ec_pkg::SAMPLE_W-1:0] sample;
	logic                                   block_start;

	modport source (output valid, output sample, output block_start, input ready);
	modport sink   (input valid, input sample, input block_start, output ready);
endinterface

// File: hdl/fir_ec_out_if.sv
// fir_ec_out_if: result request channel (valid/ready plus filtered).
// Depends on fir_ec_pkg.
interface fir_ec_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [fir_ec_pkg::OUT_W-1:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink   (input valid, input filtered, output ready);
endinterface

// File: hdl/fir_ec_cfg.sv
// fir_ec_cfg: APB coefficient register file.
// Depends on fir_ec_pkg.
module fir_ec_cfg #(
	parameter int TAPS = fir_ec_pkg::TAPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fir_ec_pkg::PADDR_W-1:0]        paddr,
	input  logic [fir_ec_pkg::PDATA_W-1:0]        pwdata,
	output logic [fir_ec_pkg::PDATA_W-1:0]        prdata,
	output logic                                  pready,
	output logic signed [fir_ec_pkg::COEFF_W-1:0] coeff [TAPS]
);

	localparam int IDX_LO = fir_ec_pkg::PADDR_W - fir_ec_pkg::REG_IDX_W;
	localparam int EXT_W  = fir_ec_pkg::PDATA_W - fir_ec_pkg::COEFF_W;

	logic                                  wr_en;
	logic [fir_ec_pkg::REG_IDX_W-1:0]      reg_idx;
	logic signed [fir_ec_pkg::COEFF_W-1:0] coeff_q [TAPS];

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[fir_ec_pkg::PADDR_W-1:IDX_LO];
	assign coeff   = coeff_q;

	// taps beyond the bus register list stay at their reset value of zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				coeff_q[k] <= (k == 0) ? fir_ec_pkg::COEFF0_RST : '0;
			end
		end else if (wr_en) begin
			for (int k = 0; k < TAPS; k++) begin
				if (k < fir_ec_pkg::NUM_REGS &&
				    reg_idx == fir_ec_pkg::REG_IDX_W'(k)) begin
					coeff_q[k] <= pwdata[fir_ec_pkg::COEFF_W-1:0];
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int k = 0; k < TAPS; k++) begin
			if (k < fir_ec_pkg::NUM_REGS && reg_idx == fir_ec_pkg::REG_IDX_W'(k)) begin
				prdata = {{EXT_W{coeff_q[k][fir_ec_pkg::COEFF_W-1]}}, coeff_q[k]};
			end
		end
	end

endmodule

// File: hdl/fir_ec_dline.sv
// fir_ec_dline: input stage; sample history with block-start fill, registers the tap vector.
// Depends on fir_ec_pkg, fir_ec_in_if.
module fir_ec_dline #(
	parameter int TAPS = fir_ec_pkg::TAPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	fir_ec_in_if.sink                              samples,
	input  logic                                   rdy_s1,
	output logic                                   vld_s1,
	output logic signed [fir_ec_pkg::SAMPLE_W-1:0] tap_s1 [TAPS]
);

	localparam int HIST_D = (TAPS > 1) ? TAPS - 1 : 1;

	logic                                   accept;
	logic                                   take;
	logic signed [fir_ec_pkg::SAMPLE_W-1:0] tap_nxt [TAPS];
	logic signed [fir_ec_pkg::SAMPLE_W-1:0] hist_q  [HIST_D];

	// stage 1 frees up when empty or when stage 2 takes its content
	assign take          = !vld_s1 || rdy_s1;
	assign samples.ready = take;
	assign accept        = samples.valid && take;

	// block_start repeats the sample over every older tap
	always_comb begin
		tap_nxt[0] = samples.sample;
		for (int k = 1; k < TAPS; k++) begin
			tap_nxt[k] = samples.block_start ? samples.sample : hist_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k < HIST_D; k++) begin
				hist_q[k] <= '0;
			end
		end else begin
			if (take) begin
				vld_s1 <= samples.valid;
			end
			if (accept) begin
				// new history equals the first TAPS-1 taps of this item
				for (int k = 0; k < HIST_D; k++) begin
					hist_q[k] <= tap_nxt[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tap_s1 <= tap_nxt;
		end
	end

endmodule

// File: hdl/fir_ec_mac.sv
// fir_ec_mac: tap products, grouped partial sums and the result register.
// Depends on fir_ec_pkg, fir_ec_out_if.
module fir_ec_mac #(
	parameter int TAPS = fir_ec_pkg::TAPS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   vld_s1,
	input  logic signed [fir_ec_pkg::SAMPLE_W-1:0] tap_s1 [TAPS],
	input  logic signed [fir_ec_pkg::COEFF_W-1:0]  coeff  [TAPS],
	output logic                                   rdy_s1,
	fir_ec_out_if.source                           results
);

	localparam int PW   = fir_ec_pkg::PROD_W;
	localparam int OW   = fir_ec_pkg::OUT_W;
	localparam int NGRP = (TAPS + fir_ec_pkg::GRP - 1) / fir_ec_pkg::GRP;

	logic                 vld_s2, vld_s3, out_vld_q;
	logic                 rdy_s2, rdy_s3, rdy_out;
	logic signed [PW-1:0] prod_s2 [TAPS];
	logic signed [OW-1:0] grp_s3  [NGRP];
	logic signed [OW-1:0] grp_sum [NGRP];
	logic signed [OW-1:0] total;
	logic signed [OW-1:0] filtered_q;

	// per-stage ready: a stage moves when empty or when the next one moves
	assign rdy_out = !out_vld_q || results.ready;
	assign rdy_s3  = !vld_s3 || rdy_out;
	assign rdy_s2  = !vld_s2 || rdy_s3;
	assign rdy_s1  = rdy_s2;

	assign results.valid    = out_vld_q;
	assign results.filtered = filtered_q;

	// products sign-extended to the result width; wraps mod 2^OUT_W for large TAPS
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_sum[g] = '0;
			for (int j = 0; j < fir_ec_pkg::GRP; j++) begin
				if (g * fir_ec_pkg::GRP + j < TAPS) begin
					grp_sum[g] = grp_sum[g] +
					    {{(OW-PW){prod_s2[g*fir_ec_pkg::GRP+j][PW-1]}},
					     prod_s2[g*fir_ec_pkg::GRP+j]};
				end
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + grp_s3[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s2[k] <= coeff[k] * tap_s1[k];
			end
		end
		if (rdy_s3 && vld_s2) begin
			grp_s3 <= grp_sum;
		end
		if (rdy_out && vld_s3) begin
			filtered_q <= total;
		end
	end

endmodule

// File: hdl/fir_filter_edge_clamped.sv
// Edge-clamped direct-form FIR filter. Each accepted request carries one signed 16-bit
// sample and a block_start flag; each produces exactly one result request with the
// full-precision sum y[n] = sum_k coeff_k * x[n-k] (35 bits signed, 15 fractional bits,
// no rounding, wraps to 35 bits only if TAPS is raised past the default). A sample with
// block_start set first fills the whole history with itself, so a block behaves as if
// its first sample had always been there. After reset the history is zero, coeff_0 is
// 32767 (about 1.0) and the other coefficients are 0, i.e. a pass-through scaled by
// 2^15. Throughput is one sample per clock while results are taken without stall; an
// accepted sample passes through the tap, product, partial-sum and result registers
// in that order before the result is presented, since the multiplies and each adder
// level have a stage of their own. Each stage has its own valid and stalls only when
// full and blocked, so input keeps flowing into empty stages while a finished result
// waits. Coefficients sit on an APB port at byte address 4*k for k = 0..7; write them
// only while the pipeline is empty.
// Depends on fir_ec_pkg, fir_ec_in_if, fir_ec_out_if, fir_ec_cfg, fir_ec_dline, fir_ec_mac.
module fir_filter_edge_clamped #(
	parameter int TAPS = fir_ec_pkg::TAPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fir_ec_in_if.sink                      samples,
	fir_ec_out_if.source                   results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fir_ec_pkg::PADDR_W-1:0] paddr,
	input  logic [fir_ec_pkg::PDATA_W-1:0] pwdata,
	output logic [fir_ec_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);

	// coefficient bank, read in parallel by the multipliers
	logic signed [fir_ec_pkg::COEFF_W-1:0]  coeff  [TAPS];
	// tap vector handoff from the input stage
	logic signed [fir_ec_pkg::SAMPLE_W-1:0] tap_s1 [TAPS];
	logic                                   vld_s1;
	logic                                   rdy_s1;

	fir_ec_cfg #(.TAPS(TAPS)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coeff   (coeff)
	);

	// history shift and block-start fill happen at the accepting edge
	fir_ec_dline #(.TAPS(TAPS)) u_dline (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.rdy_s1  (rdy_s1),
		.vld_s1  (vld_s1),
		.tap_s1  (tap_s1)
	);

	// multiply, partial sums in groups of four, final sum into the result register
	fir_ec_mac #(.TAPS(TAPS)) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.tap_s1  (tap_s1),
		.coeff   (coeff),
		.rdy_s1  (rdy_s1),
		.results (results)
	);

endmodule

// File: test/tb_fir_filter_edge_clamped.sv
`timescale 1ns / 100ps
// tb_fir_filter_edge_clamped: self-checking bench for the edge-clamped FIR filter.
// Holds its own tap/delay-line predictor and a result scoreboard.
// Depends on fir_ec_pkg, fir_ec_in_if, fir_ec_out_if and the fir_filter_edge_clamped RTL.
module tb_fir_filter_edge_clamped;

	localparam int NTAPS = fir_ec_pkg::TAPS_DEF;

	typedef logic signed [fir_ec_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic signed [fir_ec_pkg::COEFF_W-1:0]  coeff_t;
	typedef logic signed [fir_ec_pkg::OUT_W-1:0]    filtered_t;

	// Mirror of the filter: coefficients, delay line and the queue of sums not yet seen.
	class fir_scoreboard;
		coeff_t    taps [NTAPS];
		sample_t   delay [NTAPS-1];    // entry 0 is the newest sample
		filtered_t filtered_due [$];
		int        errors;

		function new();
			foreach (taps[k]) taps[k] = '0;
			foreach (delay[k]) delay[k] = '0;
			taps[0] = fir_ec_pkg::COEFF0_RST;
			errors = 0;
		endfunction

		function void set_tap(int idx, coeff_t value);
			taps[idx] = value;
		endfunction

		function int pending();
			return filtered_due.size();
		endfunction

		// Accepted sample: clamp history on block start, sum the products, shift.
		function void note_sample(sample_t x, logic start);
			longint acc;
			if (start)
				foreach (delay[k]) delay[k] = x;
			acc = longint'(taps[0]) * longint'(x);
			for (int k = 1; k < NTAPS; k++)
				acc += longint'(taps[k]) * longint'(delay[k-1]);
			for (int k = NTAPS - 2; k > 0; k--)
				delay[k] = delay[k-1];
			delay[0] = x;
			filtered_due.push_back(filtered_t'(acc));
		endfunction

		function void check_filtered(filtered_t got);
			filtered_t want;
			if (filtered_due.size() == 0) begin
				$error("filtered: expected nothing, actual %0d", got);
				errors++;
				return;
			end
			want = filtered_due.pop_front();
			if (got !== want) begin
				$error("filtered: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [fir_ec_pkg::PADDR_W-1:0]    paddr = '0;
	logic [fir_ec_pkg::PDATA_W-1:0]    pwdata = '0;
	logic [fir_ec_pkg::PDATA_W-1:0]    prdata;
	logic                              pready;
	logic                              rx_ready = 1'b0;

	fir_ec_in_if  samples_if ();
	fir_ec_out_if results_if ();

	assign results_if.ready = rx_ready;

	fir_filter_edge_clamped uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fir_scoreboard board;
	bit            jitter_on = 1'b1;    // random idle bursts on both sides
	int            stall_left = 0;
	coeff_t        tap_plan [NTAPS];

	always #5 clk = ~clk;

	// Hard stop if the pipeline hangs: far beyond the slowest legal run.
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: check every accepted request, then decide ready for the next cycle.
	// Stalls come in bursts so back-pressure lands on every pipeline stage.
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_if.valid && results_if.ready)
				board.check_filtered(results_if.filtered);
			if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					rx_ready <= 1'b1;
			end else if (jitter_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10);
				rx_ready <= 1'b0;
			end else begin
				rx_ready <= 1'b1;
			end
		end
	end

	// APB write: setup cycle, access cycle, then an idle gap so back-to-back
	// writes never touch psel twice in one step. Mirror updates at the access edge.
	task automatic apb_write(input int idx, input coeff_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= fir_ec_pkg::PADDR_W'(idx * 4);
		pwdata  <= fir_ec_pkg::PDATA_W'(value);    // upper bits follow the sign
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_tap(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_taps();
		for (int k = 0; k < NTAPS; k++)
			apb_write(k, tap_plan[k]);
	endtask

	// Offer one sample request, optionally after an idle burst; returns at the
	// accepting edge with valid still high.
	task automatic send_sample(input sample_t x, input logic start);
		int gap;
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid       <= 1'b1;
		samples_if.sample      <= x;
		samples_if.block_start <= start;
		do @(posedge clk); while (!samples_if.ready);
		board.note_sample(x, start);
	endtask

	// Stop offering and wait for the pipeline to empty out; taps change only then.
	task automatic drain();
		samples_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic coeff_t pick_coeff();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			3: return coeff_t'($urandom_range(0, 511)) - 16'sd256;
			default: return coeff_t'($urandom);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return sample_t'($urandom_range(0, 63)) - 16'sd32;
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int left;
		logic start;

		board = new();
		samples_if.valid       = 1'b0;
		samples_if.sample      = '0;
		samples_if.block_start = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset taps: plain pass-through scaled by 2^15, history never clamped yet.
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sh5555, 1'b0);
		drain();

		// All taps at the most negative value: block start with the most negative
		// sample gives the largest possible positive sum.
		foreach (tap_plan[k]) tap_plan[k] = -16'sd32768;
		load_taps();
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd32767, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		drain();

		// All taps at the most positive value.
		foreach (tap_plan[k]) tap_plan[k] = 16'sd32767;
		load_taps();
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd32767, 1'b1);
		drain();

		// Distinct taps with alternating signs: an impulse walks through the delay
		// line and shows each tap in order; then a block start in mid-stream.
		foreach (tap_plan[k]) tap_plan[k] = (k % 2) ? -coeff_t'(1000 * (k + 1))
			: coeff_t'(1000 * (k + 1));
		load_taps();
		send_sample('0, 1'b1);
		send_sample(16'sd256, 1'b0);
		for (int n = 0; n < NTAPS - 1; n++)
			send_sample('0, 1'b0);
		send_sample(-16'sd7, 1'b1);
		drain();

		// Random phases: fresh taps each time, mostly well-formed blocks of random
		// length, some blocks without a start flag and a few stray starts.
		for (int phase = 0; phase < 6; phase++) begin
			jitter_on = (phase != 5);    // last stretch runs at full rate
			foreach (tap_plan[k]) tap_plan[k] = pick_coeff();
			load_taps();
			left = 0;
			for (int n = 0; n < 285; n++) begin
				if (left == 0) begin
					left  = $urandom_range(1, 40);
					start = ($urandom_range(0, 9) != 0);
				end else begin
					start = ($urandom_range(0, 49) == 0);
				end
				left--;
				send_sample(pick_sample(), start);
			end
			drain();
		end

		// Catch any stray result after the last expected one.
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
